// ----- rtl/core/ntc_pkg.sv -----
package ntc_pkg;

	// calibration rom geometry
	localparam int ROM_DEPTH        = 64;
	localparam int TABLE_POINTS_DEF = 13;
	localparam int IDX_W            = $clog2(ROM_DEPTH);

	// field widths
	localparam int ADC_W  = 10;
	localparam int TEMP_W = 10;

	// reciprocal scaling for the segment divide
	localparam int RECIP_W = 16;
	localparam int FRAC_W  = 20;
	localparam int PROD_W  = 2 * ADC_W;

	// queue between classifier and arithmetic pipe, power of two
	localparam int QUEUE_DEPTH = 2;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		KIND_LERP = 2'd0,
		KIND_COLD = 2'd1,
		KIND_HOT  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [ADC_W-1:0] adc;
		idx_t             seg;
		kind_t            kind;
	} item_t;

	// calibration temperatures in tenths of a degree, unused entries are zero
	function automatic logic signed [TEMP_W-1:0] cal_tenths(input idx_t idx);
		logic signed [TEMP_W-1:0] t;
		case (idx)
			6'd0:    t = -10'sd150;
			6'd1:    t = -10'sd100;
			6'd2:    t = -10'sd50;
			6'd3:    t = 10'sd0;
			6'd4:    t = 10'sd50;
			6'd5:    t = 10'sd100;
			6'd6:    t = 10'sd150;
			6'd7:    t = 10'sd200;
			6'd8:    t = 10'sd250;
			6'd9:    t = 10'sd300;
			6'd10:   t = 10'sd350;
			6'd11:   t = 10'sd400;
			6'd12:   t = 10'sd450;
			default: t = 10'sd0;
		endcase
		return t;
	endfunction

	// calibration adc codes, strictly descending, unused entries are zero
	function automatic logic [ADC_W-1:0] cal_code(input idx_t idx);
		logic [ADC_W-1:0] c;
		case (idx)
			6'd0:    c = 10'd980;
			6'd1:    c = 10'd823;
			6'd2:    c = 10'd680;
			6'd3:    c = 10'd557;
			6'd4:    c = 10'd452;
			6'd5:    c = 10'd366;
			6'd6:    c = 10'd295;
			6'd7:    c = 10'd238;
			6'd8:    c = 10'd192;
			6'd9:    c = 10'd156;
			6'd10:   c = 10'd127;
			6'd11:   c = 10'd103;
			6'd12:   c = 10'd85;
			default: c = 10'd0;
		endcase
		return c;
	endfunction

	// floor(2^FRAC_W / span) for the segment ending at idx, zero where span is zero
	function automatic logic [RECIP_W-1:0] seg_recip(input idx_t idx);
		logic [RECIP_W-1:0] r;
		case (idx)
			6'd1:    r = 16'd6678;
			6'd2:    r = 16'd7332;
			6'd3:    r = 16'd8525;
			6'd4:    r = 16'd9986;
			6'd5:    r = 16'd12192;
			6'd6:    r = 16'd14768;
			6'd7:    r = 16'd18396;
			6'd8:    r = 16'd22795;
			6'd9:    r = 16'd29127;
			6'd10:   r = 16'd36157;
			6'd11:   r = 16'd43690;
			6'd12:   r = 16'd58254;
			6'd13:   r = 16'd12336;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/core/ntc_table_interpolator.sv -----
// path: a reading is written to the queue, then passes stages 1 to 5 and the output register before its result is valid
// throughput: one reading per cycle while the output is not stalled, set by the fully pipelined reciprocal divide
// while the output is stalled the 2-entry queue keeps taking readings until it holds 2
// reset: arst_n clears the queue pointers and all pipeline valid bits at once
// the calibration table is constant logic and needs no initialisation
module ntc_table_interpolator import ntc_pkg::*; #(
	parameter int TABLE_POINTS = TABLE_POINTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     sample_valid,
	output logic                     sample_ready,
	input  logic [ADC_W-1:0]         adc,
	output logic                     result_valid,
	input  logic                     result_ready,
	output logic signed [TEMP_W-1:0] temperature,
	output logic                     clamped
);

	logic  push_valid;
	item_t push_item;
	item_t head;
	logic  q_full;
	logic  q_empty;
	logic  pop;

	// classifier
	ntc_front #(
		.TABLE_POINTS(TABLE_POINTS)
	) u_front (
		.adc         (adc),
		.sample_valid(sample_valid),
		.push_valid  (push_valid),
		.push_item   (push_item)
	);

	// queue between classifier and arithmetic
	ntc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_valid),
		.push_item(push_item),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	assign sample_ready = !q_full;

	// interpolation pipeline
	ntc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (!q_empty),
		.pop         (pop),
		.temperature (temperature),
		.clamped     (clamped),
		.result_valid(result_valid),
		.result_ready(result_ready)
	);

endmodule

// ----- rtl/core/ntc_front.sv -----
module ntc_front import ntc_pkg::*; #(
	parameter int TABLE_POINTS = TABLE_POINTS_DEF
) (
	input  logic [ADC_W-1:0] adc,
	input  logic             sample_valid,
	output logic             push_valid,
	output item_t            push_item
);

	localparam int NPTS = (TABLE_POINTS < 2) ? 2 :
		((TABLE_POINTS > ROM_DEPTH) ? ROM_DEPTH : TABLE_POINTS);

	logic [ROM_DEPTH-1:0] above;
	idx_t                 hit;
	logic                 found;

	// reading against every calibration point in parallel
	always_comb begin
		for (int i = 0; i < ROM_DEPTH; i++) begin
			above[i] = (i < NPTS) && (adc > cal_code(IDX_W'(i)));
		end
	end

	// first point whose code lies below the reading
	always_comb begin
		hit   = '0;
		found = 1'b0;
		for (int i = ROM_DEPTH - 1; i >= 0; i--) begin
			if (above[i]) begin
				hit   = IDX_W'(i);
				found = 1'b1;
			end
		end
	end

	// classify into clamp or interpolation segment
	always_comb begin
		push_item.adc = adc;
		if (!found) begin
			push_item.kind = KIND_HOT;
			push_item.seg  = IDX_W'(NPTS - 1);
		end else if (hit == '0) begin
			push_item.kind = KIND_COLD;
			push_item.seg  = '0;
		end else begin
			push_item.kind = KIND_LERP;
			push_item.seg  = hit;
		end
	end

	assign push_valid = sample_valid;

endmodule

// ----- rtl/core/ntc_queue.sv -----
module ntc_queue import ntc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head,
	output logic  full,
	output logic  empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slots_q[rd_ptr_q];

	// slot storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/core/ntc_back.sv -----
module ntc_back import ntc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  item_t                    head,
	input  logic                     head_valid,
	output logic                     pop,
	output logic signed [TEMP_W-1:0] temperature,
	output logic                     clamped,
	output logic                     result_valid,
	input  logic                     result_ready
);

	localparam int MUL_W = PROD_W + RECIP_W;

	logic adv;

	// stage 1 lookup
	idx_t                     prev_idx;
	logic signed [TEMP_W-1:0] t_lo;
	logic signed [TEMP_W-1:0] t_hi;
	logic        [ADC_W-1:0]  a_lo;
	logic        [ADC_W-1:0]  a_hi;
	logic signed [TEMP_W:0]   dt;
	logic        [TEMP_W:0]   dt_abs;
	logic                     is_clamp;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [TEMP_W-1:0] base_s1, base_s2, base_s3, base_s4, base_s5;
	logic                     neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic                     clamp_s1, clamp_s2, clamp_s3, clamp_s4, clamp_s5;
	logic        [ADC_W-1:0]  mag_s1;
	logic        [ADC_W-1:0]  x_s1;
	logic        [ADC_W-1:0]  den_s1, den_s2, den_s3, den_s4;
	logic        [RECIP_W-1:0] recip_s1, recip_s2;
	logic        [PROD_W-1:0] m_s2, m_s3, m_s4;
	logic        [ADC_W-1:0]  q_s3, q_s4, qf_s5;
	logic        [PROD_W-1:0] qd_s4;

	logic        [MUL_W-1:0]  est_prod;
	logic        [PROD_W-1:0] rem;
	logic                     bump;
	logic        [ADC_W-1:0]  step;

	// whole pipe moves when the output register is free or being drained
	assign adv          = !result_valid || result_ready;
	assign pop          = adv && head_valid;

	// segment constants and operand forming
	always_comb begin
		prev_idx = head.seg - IDX_W'(1);
		t_lo     = cal_tenths(prev_idx);
		t_hi     = cal_tenths(head.seg);
		a_lo     = cal_code(prev_idx);
		a_hi     = cal_code(head.seg);
		case (head.kind)
			KIND_LERP: is_clamp = 1'b0;
			KIND_COLD: is_clamp = 1'b1;
			KIND_HOT:  is_clamp = 1'b1;
			default:   is_clamp = 1'b1;
		endcase
		dt     = {t_hi[TEMP_W-1], t_hi} - {t_lo[TEMP_W-1], t_lo};
		dt_abs = dt[TEMP_W] ? (~dt + 1'b1) : dt;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			base_s1  <= is_clamp ? t_hi : t_lo;
			neg_s1   <= dt[TEMP_W];
			mag_s1   <= is_clamp ? '0 : dt_abs[ADC_W-1:0];
			x_s1     <= a_lo - head.adc;
			den_s1   <= a_lo - a_hi;
			recip_s1 <= seg_recip(head.seg);
			clamp_s1 <= is_clamp;
		end
	end

	// stage 2: scaled offset, |dt| * (a_lo - adc)
	always_ff @(posedge clk) begin
		if (adv) begin
			m_s2     <= PROD_W'(mag_s1 * x_s1);
			base_s2  <= base_s1;
			neg_s2   <= neg_s1;
			den_s2   <= den_s1;
			recip_s2 <= recip_s1;
			clamp_s2 <= clamp_s1;
		end
	end

	// stage 3: quotient estimate through the reciprocal, low by at most one
	assign est_prod = MUL_W'(m_s2) * MUL_W'(recip_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s3     <= est_prod[FRAC_W +: ADC_W];
			m_s3     <= m_s2;
			base_s3  <= base_s2;
			neg_s3   <= neg_s2;
			den_s3   <= den_s2;
			clamp_s3 <= clamp_s2;
		end
	end

	// stage 4: back-multiply for the remainder check
	always_ff @(posedge clk) begin
		if (adv) begin
			qd_s4    <= PROD_W'(q_s3 * den_s3);
			q_s4     <= q_s3;
			m_s4     <= m_s3;
			base_s4  <= base_s3;
			neg_s4   <= neg_s3;
			den_s4   <= den_s3;
			clamp_s4 <= clamp_s3;
		end
	end

	// stage 5: remainder correction, zero step for clamps and empty spans
	assign rem  = m_s4 - qd_s4;
	assign bump = (rem >= PROD_W'(den_s4));

	always_ff @(posedge clk) begin
		if (adv) begin
			qf_s5    <= (clamp_s4 || den_s4 == '0) ? '0 : (q_s4 + ADC_W'(bump));
			base_s5  <= base_s4;
			neg_s5   <= neg_s4;
			clamp_s5 <= clamp_s4;
		end
	end

	// output register, signed step applied to the base temperature
	assign step = neg_s5 ? (~qf_s5 + 1'b1) : qf_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			temperature <= base_s5 + signed'(TEMP_W'(step));
			clamped     <= clamp_s5;
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			v_s5         <= 1'b0;
			result_valid <= 1'b0;
		end else if (adv) begin
			v_s1         <= head_valid;
			v_s2         <= v_s1;
			v_s3         <= v_s2;
			v_s4         <= v_s3;
			v_s5         <= v_s4;
			result_valid <= v_s5;
		end
	end

endmodule

// ----- tb/sv/ntc_reading_checker.sv -----
module ntc_reading_checker import ntc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     sample_valid,
	input  logic                     sample_ready,
	input  logic [ADC_W-1:0]         adc,
	input  logic                     result_valid,
	input  logic                     result_ready,
	input  logic signed [TEMP_W-1:0] temperature,
	input  logic                     clamped,
	output int                       fail_count,
	output int                       pending
);

	localparam int CAL_POINTS = 13;
	localparam int MAX_REPORTS = 10;

	// calibration points: tenths of a degree against descending adc code
	localparam int CAL_TENTHS [CAL_POINTS] = '{
		-150, -100, -50, 0, 50, 100, 150, 200, 250, 300, 350, 400, 450
	};
	localparam int CAL_ADC [CAL_POINTS] = '{
		980, 823, 680, 557, 452, 366, 295, 238, 192, 156, 127, 103, 85
	};

	typedef struct {
		logic signed [TEMP_W-1:0] temperature;
		logic                     clamped;
	} conversion_t;

	conversion_t expected_temps [$];
	conversion_t want;
	int          reports = 0;

	// linear interpolation on the segment below the first code under the reading
	function automatic conversion_t interpolate_temperature(input logic [ADC_W-1:0] reading);
		conversion_t res;
		int          hit;
		int          t0, t1, a0, a1, num, den, step;
		hit = -1;
		for (int i = 0; i < CAL_POINTS; i++)
			if (hit < 0 && int'(reading) > CAL_ADC[i])
				hit = i;
		if (hit < 0) begin
			// at or below the hottest point
			res.temperature = TEMP_W'(CAL_TENTHS[CAL_POINTS-1]);
			res.clamped     = 1'b1;
		end else if (hit == 0) begin
			// above the coldest point
			res.temperature = TEMP_W'(CAL_TENTHS[0]);
			res.clamped     = 1'b1;
		end else begin
			t0   = CAL_TENTHS[hit-1];
			t1   = CAL_TENTHS[hit];
			a0   = CAL_ADC[hit-1];
			a1   = CAL_ADC[hit];
			num  = (t1 - t0) * (int'(reading) - a0);
			den  = a1 - a0;
			// integer divide truncates toward zero
			step = (den != 0) ? num / den : 0;
			res.temperature = TEMP_W'(t0 + step);
			res.clamped     = 1'b0;
		end
		return res;
	endfunction

	// compare each result transaction, then record the reading transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_temps.size() == 0) begin
					fail_count = fail_count + 1;
					if (reports < MAX_REPORTS) begin
						reports = reports + 1;
						$display("unexpected result: temperature %0d clamped %0b",
							temperature, clamped);
					end
				end else begin
					want = expected_temps.pop_front();
					if (temperature !== want.temperature || clamped !== want.clamped) begin
						fail_count = fail_count + 1;
						if (reports < MAX_REPORTS) begin
							reports = reports + 1;
							$display("mismatch: temperature exp %0d got %0d, clamped exp %0b got %0b",
								want.temperature, temperature, want.clamped, clamped);
						end
					end
				end
			end
			if (sample_valid && sample_ready)
				expected_temps.push_back(interpolate_temperature(adc));
			pending = expected_temps.size();
		end
	end

endmodule

// ----- tb/sv/tb.sv -----
module tb;
	import ntc_pkg::*;

	localparam int RANDOM_READINGS = 1250;
	localparam int IDLE_LIMIT      = 1000;
	localparam int SETTLE_CYCLES   = 20;

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     sample_valid = 1'b0;
	logic                     sample_ready;
	logic [ADC_W-1:0]         adc          = '0;
	logic                     result_valid;
	logic                     result_ready = 1'b0;
	logic signed [TEMP_W-1:0] temperature;
	logic                     clamped;
	int                       fail_count;
	int                       pending;
	int                       idle_cycles  = 0;
	int                       stall_tick   = 0;
	int                       stall_left   = 0;

	ntc_table_interpolator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.adc          (adc),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.temperature  (temperature),
		.clamped      (clamped)
	);

	ntc_reading_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.adc          (adc),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.temperature  (temperature),
		.clamped      (clamped),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stalls, cycling through four styles in turn
	always @(negedge clk) begin
		stall_tick <= stall_tick + 1;
		case ((stall_tick / 256) % 4)
			0: result_ready <= 1'b1;
			1: result_ready <= 1'($urandom_range(0, 1));
			2: result_ready <= (stall_tick % 8) < 5;
			default: begin
				if (stall_left > 0) begin
					stall_left   <= stall_left - 1;
					result_ready <= 1'b0;
				end else if ($urandom_range(0, 19) == 0) begin
					stall_left   <= $urandom_range(4, 16);
					result_ready <= 1'b0;
				end else begin
					result_ready <= 1'b1;
				end
			end
		endcase
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("ntc_table_interpolator verification failed");
			$finish;
		end
	end

	// hold one reading until its transaction completes, return at the next falling edge
	task automatic send_reading(input logic [ADC_W-1:0] value);
		sample_valid = 1'b1;
		adc          = value;
		do @(posedge clk); while (!sample_ready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		int sent;
		int burst;
		int gap;
		int pick;
		int near;
		bit paused;

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: range ends, just past the cold end, every breakpoint, around the hot end, two alternating bit patterns
		send_reading(10'd0);
		send_reading(10'd1023);
		send_reading(10'd981);
		for (int i = 0; i < TABLE_POINTS_DEF; i++)
			send_reading(cal_code(idx_t'(i)));
		send_reading(10'd86);
		send_reading(10'd84);
		send_reading(10'h155);
		send_reading(10'h2aa);
		sample_valid = 1'b0;
		drain_results();

		// random bursts, mostly anywhere, some hugging breakpoints and clamp regions
		sent   = 0;
		paused = 1'b0;
		while (sent < RANDOM_READINGS) begin
			burst = $urandom_range(1, 24);
			for (int b = 0; b < burst && sent < RANDOM_READINGS; b++) begin
				pick = $urandom_range(0, 9);
				if (pick <= 5) begin
					send_reading(ADC_W'($urandom_range(0, 1023)));
				end else if (pick <= 7) begin
					near = int'(cal_code(idx_t'($urandom_range(0, TABLE_POINTS_DEF - 1))))
						+ int'($urandom_range(0, 4)) - 2;
					send_reading(ADC_W'(near));
				end else if (pick == 8) begin
					send_reading(ADC_W'($urandom_range(981, 1023)));
				end else begin
					send_reading(ADC_W'($urandom_range(0, 85)));
				end
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (!paused && sent >= RANDOM_READINGS / 2) begin
				// hold off until the pipe is empty
				paused       = 1'b1;
				sample_valid = 1'b0;
				drain_results();
			end
			if (gap > 0) begin
				sample_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		sample_valid = 1'b0;

		// wait out the pipe, then the verdict
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("ntc_table_interpolator verification clean");
		else
			$display("ntc_table_interpolator verification failed");
		$finish;
	end

endmodule
